// ===== rtl/sofs_pkg.sv =====
// Shared types, codes and constants for the slab object free stack.
`default_nettype none

package sofs_pkg;

   localparam int MAX_OBJECTS_DEF = 256;
   localparam int ADDR_W          = 32;
   localparam int SIZE_W          = 18;
   localparam int COUNT_W         = 9;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [SIZE_W-1:0]  OBJECT_SIZE_RST  = 18'd32;
   localparam logic [COUNT_W-1:0] OBJECT_COUNT_RST = 9'd128;
   localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'd0;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_OUTSIDE = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OBJECT_SIZE  = 2'd0,
      CSR_OBJECT_COUNT = 2'd1,
      CSR_BASE_ADDRESS = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic              start;
      arith_op_type      op;
      logic [ADDR_W-1:0] operand;
   } arith_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] result;
   } arith_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/sofs_arith.sv =====
// Iterative shift/add unit: base + size * index, or (address - base) / size.
`default_nettype none

module sofs_arith
   import sofs_pkg::*;
#(
   parameter int IDX_W = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SIZE_W-1:0]   object_size,
   input  wire logic [ADDR_W-1:0]   base_address,
   input  wire arith_req_type       req,
   output      arith_rsp_type       rsp
);

   localparam int CNT_W = $clog2(ADDR_W + 1);
   localparam int REM_W = SIZE_W + 1;

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_PRE  = 4'b0010,
      U_LOOP = 4'b0100,
      U_POST = 4'b1000
   } ustate_type;

   ustate_type          state_ff, state_in;
   arith_op_type        op_ff, op_in;
   logic [ADDR_W-1:0]   acc_ff, acc_in;
   logic [ADDR_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [ADDR_W-1:0]   result_ff, result_in;

   // the one shared adder
   logic [ADDR_W-1:0]   opa, opb;
   logic                sub;
   logic [ADDR_W:0]     sum;
   logic [REM_W-1:0]    rem_shift;

   assign rem_shift = {acc_ff[SIZE_W-1:0], quo_ff[ADDR_W-1]};
   assign sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{ADDR_W{1'b0}}, sub};

   always_comb begin
      opa = acc_ff;
      opb = base_address;
      sub = 1'b0;
      case (state_ff)
         U_PRE: begin
            opa = quo_ff;
            opb = base_address;
            sub = 1'b1;
         end
         U_LOOP: begin
            if (op_ff == OP_DIV) begin
               opa = ADDR_W'(rem_shift);
               opb = ADDR_W'(object_size);
               sub = 1'b1;
            end else begin
               opa = {acc_ff[ADDR_W-2:0], 1'b0};
               opb = quo_ff[ADDR_W-1] ? ADDR_W'(object_size) : '0;
               sub = 1'b0;
            end
         end
         default: begin
            opa = acc_ff;
            opb = base_address;
            sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               op_in  = req.op;
               acc_in = '0;
               if (req.op == OP_DIV) begin
                  quo_in   = req.operand;
                  state_in = U_PRE;
               end else begin
                  // multiplier bits top-aligned, consumed msb first
                  quo_in   = req.operand << (ADDR_W - IDX_W);
                  cnt_in   = CNT_W'(IDX_W);
                  state_in = U_LOOP;
               end
            end
         end
         U_PRE: begin
            quo_in   = sum[ADDR_W-1:0];
            cnt_in   = CNT_W'(ADDR_W);
            state_in = U_LOOP;
         end
         U_LOOP: begin
            cnt_in = cnt_ff - 1'b1;
            if (op_ff == OP_DIV) begin
               // carry out set means no borrow: the divisor fits
               acc_in = sum[ADDR_W] ? sum[ADDR_W-1:0] : ADDR_W'(rem_shift);
               quo_in = {quo_ff[ADDR_W-2:0], sum[ADDR_W]};
               if (cnt_ff == CNT_W'(1)) begin
                  done_in   = 1'b1;
                  result_in = {quo_ff[ADDR_W-2:0], sum[ADDR_W]};
                  state_in  = U_IDLE;
               end
            end else begin
               acc_in = sum[ADDR_W-1:0];
               quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = U_POST;
               end
            end
         end
         U_POST: begin
            done_in   = 1'b1;
            result_in = sum[ADDR_W-1:0];
            state_in  = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      op_ff     <= op_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/slab_object_free_stack.sv =====
// Top level: slab allocator with a free-index stack and an iterative mul/div unit.
//
//   channel   ports                                        handshake
//   request   start, busy, req_command, req_address        start && !busy
//   response  rsp_valid, rsp_object_address, rsp_status,    rsp_valid, one cycle
//             rsp_objects_in_use
//   csr       csr_valid, csr_ready, csr_index, csr_wdata   csr_valid && csr_ready
//
// Free: 1 offset subtract + 32 divide steps in the shared adder, plus sequencing.
// Allocate: stack read, one multiply step per index bit, base add. Allocate on a
// full slab answers directly from idle, without the arith unit. busy is high
// while an item is in the unit. Synchronous reset; no clearing pass, unwritten
// stack entries read as their own position. Responses cannot be stalled; csr writes
// are taken at any time.
`default_nettype none

module slab_object_free_stack
   import sofs_pkg::*;
#(
   parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output      logic                   busy,
   input  wire logic                   req_command,
   input  wire logic [ADDR_W-1:0]      req_address,
   output      logic                   rsp_valid,
   output      logic [ADDR_W-1:0]      rsp_object_address,
   output      logic [1:0]             rsp_status,
   output      logic [COUNT_W-1:0]     rsp_objects_in_use,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]      csr_wdata
);

   localparam int IDX_W = $clog2(MAX_OBJECTS);
   localparam int HW_W  = $clog2(MAX_OBJECTS + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_MUL  = 4'b0100,
      S_DIV  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [SIZE_W-1:0]    object_size_ff;
   logic [COUNT_W-1:0]   object_count_ff;
   logic [ADDR_W-1:0]    base_address_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [HW_W-1:0]      hw_ff, hw_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [IDX_W-1:0]     stack_mem [MAX_OBJECTS];
   logic [IDX_W-1:0]     stack_rd_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_pos;
   logic [IDX_W-1:0]     wr_data;
   logic [IDX_W-1:0]     entry;
   logic [COUNT_W-1:0]   cap;

   arith_req_type        arith_req;
   arith_rsp_type        arith_rsp;

   sofs_arith #(
      .IDX_W (IDX_W)
   ) u_arith (
      .clock        (clock),
      .reset        (reset),
      .object_size  (object_size_ff),
      .base_address (base_address_ff),
      .req          (arith_req),
      .rsp          (arith_rsp)
   );

   assign cap = (int'(object_count_ff) > MAX_OBJECTS) ? COUNT_W'(MAX_OBJECTS)
                                                       : object_count_ff;

   // positions at or above the high-water mark were never written since reset
   assign entry = (HW_W'(count_ff) >= hw_ff) ? IDX_W'(count_ff) : stack_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_pos] <= wr_data;
      end
      stack_rd_ff <= stack_mem[IDX_W'(count_ff)];
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      hw_in             = hw_ff;
      rsp_valid_in      = 1'b0;
      rsp_addr_in       = rsp_addr_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_count_in      = rsp_count_ff;
      arith_req.start   = 1'b0;
      arith_req.op      = OP_MUL;
      arith_req.operand = '0;
      wr_en             = 1'b0;
      wr_pos            = IDX_W'(count_ff - 1'b1);
      wr_data           = IDX_W'(arith_rsp.result);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_command == CMD_FREE) begin
                  arith_req.start   = 1'b1;
                  arith_req.op      = OP_DIV;
                  arith_req.operand = req_address;
                  state_in          = S_DIV;
               end else if (count_ff >= cap) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STATUS_FULL;
                  rsp_count_in  = count_ff;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            arith_req.start   = 1'b1;
            arith_req.op      = OP_MUL;
            arith_req.operand = ADDR_W'(entry);
            state_in          = S_MUL;
         end
         S_MUL: begin
            if (arith_rsp.done) begin
               count_in      = count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = arith_rsp.result;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = count_ff + 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DIV: begin
            if (arith_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
               if (arith_rsp.result >= ADDR_W'(cap)) begin
                  rsp_status_in = STATUS_OUTSIDE;
               end else if (count_ff == '0) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_status_in = STATUS_OK;
                  count_in      = count_ff - 1'b1;
                  rsp_count_in  = count_ff - 1'b1;
                  wr_en         = 1'b1;
                  if (HW_W'(count_ff) > hw_ff) begin
                     hw_in = HW_W'(count_ff);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         hw_ff           <= '0;
         rsp_valid_ff    <= 1'b0;
         object_size_ff  <= OBJECT_SIZE_RST;
         object_count_ff <= OBJECT_COUNT_RST;
         base_address_ff <= BASE_ADDRESS_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_OBJECT_SIZE:  object_size_ff  <= csr_wdata[SIZE_W-1:0];
               CSR_OBJECT_COUNT: object_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_BASE_ADDRESS: base_address_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_object_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_objects_in_use = rsp_count_ff;

   // an accepted beat either starts work or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid_ff))
      else $error("accepted beat neither busy nor answered");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> (state_ff == S_MUL || state_ff == S_DIV))
      else $error("arith unit finished while sequencer not waiting");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= MAX_OBJECTS)
      else $error("in-use count above stack depth");

   a_hw_bound: assert property (@(posedge clock) disable iff (reset)
      int'(hw_ff) <= MAX_OBJECTS)
      else $error("stack high-water mark above depth");

   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> (rsp_valid_ff && rsp_count_ff == count_ff))
      else $error("in-use count changed without a matching response");

endmodule

`default_nettype wire
